### rtl/lpr_pkg.sv
// shared types and constants of the linear prediction residual block
// no dependencies; imported by every module of the block
`default_nettype none

package lpr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int BIAS_W    = 40;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  // seven products plus the bias stay well inside this width
  localparam int SUM_W     = 44;
  localparam int FILL_W    = 3;
  localparam int CFG_IDX_W = 4;
  localparam int MAX_TAPS  = 7;

  localparam int DEF_TAPS      = 7;
  localparam int DEF_FRAC_BITS = 16;

  // register indexes: coefficients 0..6, then the bias
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 4'd7;

  // one item as it travels along the chain of cells
  typedef struct packed {
    logic                vld;
    logic                init;
    logic [SAMPLE_W-1:0] smp;
    logic [SUM_W-1:0]    acc;
  } lpr_stage_t;

endpackage

`default_nettype wire

### rtl/lpr_cell.sv
// one cell of the predictor chain: a history tap and one multiply-accumulate stage
// depends on lpr_pkg
`default_nettype none

module lpr_cell #(
  parameter int TAPS = lpr_pkg::DEF_TAPS,
  parameter int IDX  = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  shift,
  input  wire logic [lpr_pkg::SAMPLE_W-1:0]          hist_in,
  output logic      [lpr_pkg::SAMPLE_W-1:0]          hist,
  input  wire logic [lpr_pkg::COEF_W-1:0]            coef,
  input  wire lpr_pkg::lpr_stage_t                   st_in,
  input  wire logic [TAPS-1:0][lpr_pkg::SAMPLE_W-1:0] snap_in,
  output lpr_pkg::lpr_stage_t                        st_out,
  output logic      [TAPS-1:0][lpr_pkg::SAMPLE_W-1:0] snap_out
);
  import lpr_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic        [SUM_W-1:0]  acc_next;

  assign prod     = $signed(coef) * $signed(snap_in[IDX]);
  assign acc_next = st_in.acc + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  // history tap shifts towards the older end on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (shift) begin
      hist <= hist_in;
    end
  end

  // only the valid bit is reset, the payload simply follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.vld <= 1'b0;
    end else if (en) begin
      st_out.vld <= st_in.vld;
    end
    if (en) begin
      st_out.init <= st_in.init;
      st_out.smp  <= st_in.smp;
      st_out.acc  <= acc_next;
      snap_out    <= snap_in;
    end
  end

endmodule

`default_nettype wire

### rtl/lpr_round.sv
// rounding stage: half away from zero, drop fraction bits, saturate to 16 bits
// depends on lpr_pkg
`default_nettype none

module lpr_round #(
  parameter int COEF_FRAC_BITS = lpr_pkg::DEF_FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire lpr_pkg::lpr_stage_t          st_in,
  output logic                              vld,
  output logic                              init,
  output logic [lpr_pkg::SAMPLE_W-1:0]      smp,
  output logic [lpr_pkg::SAMPLE_W-1:0]      pred
);
  import lpr_pkg::*;

  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] POS_MAX = SUM_W'(32767);
  localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'(32768);

  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [SUM_W-1:0]    q;
  logic [SAMPLE_W-1:0] pred_next;

  always_comb begin
    neg = st_in.acc[SUM_W-1];
    mag = neg ? (~st_in.acc + SUM_W'(1)) : st_in.acc;
    q   = (mag + HALF) >> COEF_FRAC_BITS;
    if (!neg) begin
      pred_next = (q > POS_MAX) ? 16'h7fff : q[SAMPLE_W-1:0];
    end else begin
      pred_next = (q > NEG_MAX) ? 16'h8000 : (~q[SAMPLE_W-1:0] + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= st_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      init <= st_in.init;
      smp  <= st_in.smp;
      pred <= pred_next;
    end
  end

endmodule

`default_nettype wire

### rtl/linear_prediction_residual.sv
// top level of the linear prediction residual block: config registers, fill
// count, chain of predictor cells, rounding stage and output register
// depends on lpr_pkg, lpr_cell and lpr_round
`default_nettype none

// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample; tuser: start_req
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: value; tuser: is_initial
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one item per clock sustained while m_axis does not stall; each item passes
// through the chain of cells (one multiply-accumulate per cell), then the
// rounding stage and then the output register
// the whole pipeline moves as one: it advances whenever the output register
// is empty or being taken, so a stall on m_axis holds every stage in place
// synchronous reset clears the fill count, history, coefficients, bias and
// all valid bits; config writes are always taken (cfg_ready tied high)

module linear_prediction_residual #(
  parameter int TAPS           = lpr_pkg::DEF_TAPS,
  parameter int COEF_FRAC_BITS = lpr_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input items
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,  // [15:0] sample
  input  wire logic                              s_axis_tuser,  // [0] start_req
  // result items
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [15:0]                            m_axis_tdata,  // [15:0] value
  output logic                                   m_axis_tuser,  // [0] is_initial
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lpr_pkg::BIAS_W-1:0]        cfg_data
);
  import lpr_pkg::*;

  // coefficient and bias registers
  logic [TAPS-1:0][COEF_W-1:0] coef;
  logic [BIAS_W-1:0]           bias;
  logic                        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      bias <= '0;
    end else if (cfg_wr) begin
      // indexes past the used taps or past the bias are ignored
      if (cfg_index == REG_BIAS) begin
        bias <= cfg_data;
      end else if (cfg_index < CFG_IDX_W'(TAPS)) begin
        coef[cfg_index[2:0]] <= cfg_data[COEF_W-1:0];
      end
    end
  end

  // pipeline advance and input acceptance
  logic en;
  logic accept;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // fill count: samples of the current signal so far, saturating at taps
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_base;
  logic              init;

  always_comb begin
    fill_base = s_axis_tuser ? '0 : fill;
    init      = fill_base < FILL_W'(TAPS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept && init) begin
      fill <= fill_base + FILL_W'(1);
    end
  end

  // chain of cells; cell 0 holds the oldest history sample
  lpr_stage_t                     st   [TAPS+1];
  logic [TAPS-1:0][SAMPLE_W-1:0]  snap [TAPS+1];
  logic [SAMPLE_W-1:0]            hist [TAPS];

  // the item enters with the bias as its starting sum and a snapshot of the
  // history as it stood before this sample was pushed
  always_comb begin
    st[0].vld  = accept;
    st[0].init = init;
    st[0].smp  = s_axis_tdata;
    st[0].acc  = {{(SUM_W-BIAS_W){bias[BIAS_W-1]}}, bias};
    for (int j = 0; j < TAPS; j++) begin
      snap[0][j] = hist[j];
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic [SAMPLE_W-1:0] hist_in;

    if (k == TAPS - 1) begin : g_newest
      assign hist_in = s_axis_tdata;
    end else begin : g_older
      assign hist_in = hist[k+1];
    end

    lpr_cell #(
      .TAPS (TAPS),
      .IDX  (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .shift    (accept),
      .hist_in  (hist_in),
      .hist     (hist[k]),
      .coef     (coef[k]),
      .st_in    (st[k]),
      .snap_in  (snap[k]),
      .st_out   (st[k+1]),
      .snap_out (snap[k+1])
    );
  end

  // rounding and saturation of the prediction
  logic                r_vld;
  logic                r_init;
  logic [SAMPLE_W-1:0] r_smp;
  logic [SAMPLE_W-1:0] r_pred;

  lpr_round #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_round (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .st_in (st[TAPS]),
    .vld   (r_vld),
    .init  (r_init),
    .smp   (r_smp),
    .pred  (r_pred)
  );

  // output register: raw sample while filling, else residual wrapped to 16 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= r_init ? r_smp : (r_smp - r_pred);
      m_axis_tuser <= r_init;
    end
  end

endmodule

`default_nettype wire

### tb/lpr_residual_checker.sv
// checker for the linear prediction residual block: follows the item and
// config channels, predicts each residual and compares it with the result
// depends on lpr_pkg only
`timescale 1ns / 100ps

module lpr_residual_checker #(
  parameter int TAPS      = lpr_pkg::DEF_TAPS,
  parameter int FRAC_BITS = lpr_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] sample
  input  logic                          s_axis_tuser,  // [0] start_req
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [15:0]                   m_axis_tdata,  // [15:0] value
  input  logic                          m_axis_tuser,  // [0] is_initial
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpr_pkg::BIAS_W-1:0]    cfg_data,
  output int                            errors,
  output int                            pending
);

  import lpr_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                is_initial;
  } residual_t;

  logic signed [COEF_W-1:0]   weight [MAX_TAPS];
  logic signed [BIAS_W-1:0]   bias;
  logic signed [SAMPLE_W-1:0] past   [MAX_TAPS];
  int                         filled;
  residual_t                  residuals_due [$];

  initial errors = 0;
  initial pending = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch at %0t ns: %s got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // weighted sum plus bias, rounded half away from zero, saturated to 16 bits
  function automatic logic [SAMPLE_W-1:0] predict_sample();
    longint acc;
    longint mag;
    longint rounded;
    acc = longint'(bias);
    for (int i = 0; i < TAPS; i++) begin
      acc += longint'(weight[i]) * longint'(past[i]);
    end
    mag = (acc < 0) ? -acc : acc;
    rounded = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (acc < 0) begin
      rounded = -rounded;
    end
    if (rounded > 32767) begin
      rounded = 32767;
    end else if (rounded < -32768) begin
      rounded = -32768;
    end
    return rounded[SAMPLE_W-1:0];
  endfunction

  function automatic residual_t encode_sample(logic signed [SAMPLE_W-1:0] smp, logic start);
    residual_t r;
    if (start) begin
      filled = 0;
    end
    if (filled < TAPS) begin
      r.value      = smp;
      r.is_initial = 1'b1;
      filled++;
    end else begin
      r.value      = smp - predict_sample();
      r.is_initial = 1'b0;
    end
    for (int i = 0; i < TAPS - 1; i++) begin
      past[i] = past[i + 1];
    end
    past[TAPS - 1] = smp;
    return r;
  endfunction

  always @(posedge clk) begin
    residual_t want;
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        weight[i] = '0;
        past[i]   = '0;
      end
      bias   = '0;
      filled = 0;
      residuals_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BIAS) begin
          bias = cfg_data;
        end else if (cfg_index < REG_BIAS) begin
          weight[3'(cfg_index - REG_COEF_0)] = cfg_data[COEF_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (residuals_due.size() == 0) begin
          report("result with nothing expected, value", m_axis_tdata, 16'h0000);
        end else begin
          want = residuals_due.pop_front();
          if (m_axis_tdata !== want.value) begin
            report("value", m_axis_tdata, want.value);
          end
          if (m_axis_tuser !== want.is_initial) begin
            report("is_initial", 16'(m_axis_tuser), 16'(want.is_initial));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        residuals_due.push_back(encode_sample(s_axis_tdata, s_axis_tuser));
      end
    end
    pending <= residuals_due.size();
  end

endmodule

### tb/tb.sv
// top of the testbench for linear_prediction_residual: clock, reset, item and
// config stimulus, random stalls on both sides and the final verdict
// depends on lpr_pkg, the block itself and lpr_residual_checker
`timescale 1ns / 100ps

module tb;

  import lpr_pkg::*;

  // item passes through the cells plus the rounding and output stages
  localparam int LATENCY         = DEF_TAPS + 2;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 125;

  localparam logic [15:0] S_MAX = 16'h7FFF;
  localparam logic [15:0] S_MIN = 16'h8000;

  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;

  // unity weight in Q7.16 and one half in the bias format
  localparam logic [BIAS_W-1:0] Q_ONE  = 40'h00_0001_0000;
  localparam logic [BIAS_W-1:0] Q_HALF = 40'h00_0000_8000;

  typedef logic [CFG_IDX_W-1:0] reg_index_t;

  // how the weights of one phase are drawn
  typedef enum int {
    STYLE_FULL,     // any bit pattern, upper data bits included
    STYLE_TYPICAL,  // small weights, predictions mostly in range
    STYLE_EDGE      // extremes, zero and unity (one half for the bias) only
  } weight_style_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;   // [15:0] sample
  logic                 s_axis_tuser  = 1'b0; // [0] start_req
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;         // [15:0] value
  logic                 m_axis_tuser;         // [0] is_initial
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [BIAS_W-1:0]    cfg_data      = '0;

  int fail_count;
  int results_due;
  int cycles = 0;
  bit calm   = 1'b0;  // when set, neither side idles
  int walk   = 0;     // slowly moving signal for the well-formed runs

  initial begin
    forever #5 clk = ~clk;
  end

  // guard against a hang anywhere in the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  linear_prediction_residual i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lpr_residual_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (fail_count),
    .pending       (results_due)
  );

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // result side: a fresh random stall, possibly none, before every item taken
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // one input item, preceded by a random gap with junk on the data lines;
  // valid stays high afterwards so back-to-back items need no second drive
  task automatic send_item(input logic [15:0] smp, input logic start);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= start;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the sender until every expected result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [BIAS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BIAS_W-1:0] draw_weight(weight_style_t style, bit is_bias);
    int v;
    case (style)
      STYLE_FULL: begin
        return BIAS_W'({$urandom, $urandom});
      end
      STYLE_TYPICAL: begin
        v = is_bias ? int'($urandom_range(0, 1 << 21)) - (1 << 20)
                    : int'($urandom_range(0, 1 << 18)) - (1 << 17);
        return BIAS_W'(v);
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return is_bias ? 40'h7F_FFFF_FFFF : 40'h00_007F_FFFF;
          1:       return is_bias ? 40'h80_0000_0000 : 40'h00_0080_0000;
          2:       return '0;
          default: return is_bias ? Q_HALF : Q_ONE;
        endcase
      end
    endcase
  endfunction

  task automatic program_predictor(input weight_style_t style);
    for (int i = 0; i < MAX_TAPS; i++) begin
      cfg_write(reg_index_t'(REG_COEF_0 + i), draw_weight(style, 1'b0));
    end
    cfg_write(REG_BIAS, draw_weight(style, 1'b1));
    // now and then poke an index with nothing behind it
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(reg_index_t'($urandom_range(REG_BIAS + 1, (1 << CFG_IDX_W) - 1)),
                BIAS_W'({$urandom, $urandom}));
    end
  endtask

  // mostly a random walk so that predictions track the signal, with some
  // full-range noise and extremes mixed in
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      6, 7: return 16'($urandom);
      8:    return $urandom_range(0, 1) ? S_MAX : S_MIN;
      9:    walk += int'($urandom_range(0, 16384)) - 8192;
      default: walk += int'($urandom_range(0, 1024)) - 512;
    endcase
    if (walk > 32767) begin
      walk = 32767;
    end else if (walk < -32768) begin
      walk = -32768;
    end
    return 16'(walk);
  endfunction

  initial begin
    logic start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset weights are zero: no start after reset, fill then pass-through
    // residuals equal to the sample
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h3039, 1'b0);
    drain();

    // predict the previous sample plus one half: half rounds away from zero,
    // and a full-scale step saturates the prediction and wraps the residual
    for (int i = 0; i < MAX_TAPS - 1; i++) begin
      cfg_write(reg_index_t'(REG_COEF_0 + i), '0);
    end
    cfg_write(reg_index_t'(REG_COEF_0 + MAX_TAPS - 1), Q_ONE);
    cfg_write(REG_BIAS, Q_HALF);
    send_item(16'd100, 1'b1);
    send_item(-16'sd100, 1'b0);
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(16'd200, 1'b0);
    send_item(-16'sd300, 1'b0);
    send_item(16'd5, 1'b0);
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(S_MAX, 1'b0);
    // start in the middle of a running signal goes back to pass-through
    send_item(-16'sd7, 1'b1);
    send_item(16'hFFFF, 1'b0);
    drain();

    // most negative weights and bias: prediction pinned at the negative rail
    for (int i = 0; i < MAX_TAPS; i++) begin
      cfg_write(reg_index_t'(REG_COEF_0 + i), 40'h00_0080_0000);
    end
    cfg_write(REG_BIAS, 40'h80_0000_0000);
    cfg_write(REG_SPARE, 40'hFF_FFFF_FFFF);
    send_item(S_MAX, 1'b1);
    repeat (MAX_TAPS) send_item(S_MAX, 1'b0);
    send_item(16'h0000, 1'b0);

    // random part: each phase a new weight set, then long signals with
    // occasional restarts
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      program_predictor(weight_style_t'(phase % 3));
      walk = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 25 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        // one hold-off in the middle of a phase while the signal continues
        if (phase == 2 && k == ITEMS_PER_PHASE / 2) begin
          drain();
        end
        start = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
        send_item(pick_sample(), start);
      end
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
